// ===== sv/periodic_point_repulsion_relaxer_assert.svh =====
// assertion macros shared by the relaxer rtl
`ifndef PERIODIC_POINT_REPULSION_RELAXER_ASSERT_SVH
`define PERIODIC_POINT_REPULSION_RELAXER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define PPRR_ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition in one cycle implies a condition in the next
`define PPRR_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/pprr_pkg.sv =====
// types, constants and helpers of the periodic point repulsion relaxer
`default_nettype none
package pprr_pkg;

    localparam int PPRR_MAX_POINTS = 64;

    // periodic images per axis, offsets -2..+2
    localparam int          IMAGES   = 5;
    localparam logic [2:0]  IMG_LAST = 3'(IMAGES - 1);

    localparam logic [47:0]        LIM_Q32  = 48'd214748365;
    localparam logic [11:0]        LIM_Q16  = 12'd3277;
    localparam logic [32:0]        TERM_MAX = 33'h1_0000_0000;
    localparam logic signed [48:0] ACC_SAT  = 49'sd140737488355327;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic CFG_FORCE_GAIN    = 1'b0;
    localparam logic CFG_ACTIVE_POINTS = 1'b1;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic        start;
        t_alu_op     op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } t_alu_rsp;

    // saturating accumulate of one signed force term
    function automatic logic signed [47:0] acc_add(input logic signed [47:0] acc,
                                                   input logic neg,
                                                   input logic [32:0] term);
        logic signed [48:0] sum;
        sum = neg ? ($signed({acc[47], acc}) - $signed({16'b0, term}))
                  : ($signed({acc[47], acc}) + $signed({16'b0, term}));
        if (sum > ACC_SAT) begin
            sum = ACC_SAT;
        end else if (sum < -ACC_SAT) begin
            sum = -ACC_SAT;
        end
        return sum[47:0];
    endfunction

    // magnitude of a saturated accumulator
    function automatic logic [46:0] acc_mag(input logic signed [47:0] acc);
        logic signed [47:0] neg;
        neg = -acc;
        return acc[47] ? neg[46:0] : acc[46:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/pprr_alu.sv =====
// shared bit-serial multiply, divide and square root unit
`default_nettype none
module pprr_alu
    import pprr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    localparam logic [63:0] SQRT_TOP = 64'h4000_0000_0000_0000;

    logic        r_busy;
    logic        r_done;
    t_alu_op     r_op;
    logic [5:0]  r_cnt;
    logic [63:0] r_acc;
    logic [63:0] r_x;
    logic [63:0] r_y;
    logic [63:0] r_res;

    logic [63:0] n_acc;
    logic [63:0] n_x;
    logic [63:0] n_y;
    logic        w_fin;
    logic [64:0] w_rem;
    logic [64:0] w_rem_sub;
    logic        w_ge;
    logic [63:0] w_trial;

    always_comb begin
        w_rem     = {r_acc, r_x[63]};
        w_rem_sub = w_rem - {1'b0, r_y};
        w_trial   = r_acc + r_y;
        w_ge      = 1'b0;
        n_acc     = r_acc;
        n_x       = r_x;
        n_y       = r_y;
        w_fin     = 1'b1;
        unique case (r_op)
            ALU_MUL: begin
                // multiplier shifts out low bit first
                n_acc = r_y[0] ? (r_acc + r_x) : r_acc;
                n_x   = {r_x[62:0], 1'b0};
                n_y   = {1'b0, r_y[63:1]};
                w_fin = (n_y == 64'd0);
            end
            ALU_DIV: begin
                // restoring division, one quotient bit per cycle
                w_ge  = (w_rem >= {1'b0, r_y});
                n_acc = w_ge ? w_rem_sub[63:0] : w_rem[63:0];
                n_x   = {r_x[62:0], w_ge};
                w_fin = (r_cnt == 6'd63);
            end
            ALU_SQRT: begin
                // digit-by-digit root, two radicand bits per cycle
                w_ge  = (r_x >= w_trial);
                n_x   = w_ge ? (r_x - w_trial) : r_x;
                n_acc = w_ge ? ({1'b0, r_acc[63:1]} + r_y) : {1'b0, r_acc[63:1]};
                n_y   = {2'b0, r_y[63:2]};
                w_fin = (n_y == 64'd0);
            end
            default: begin
                w_fin = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ALU_MUL;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= 6'd0;
                r_acc  <= 64'd0;
                r_x    <= i_req.a;
                r_y    <= (i_req.op == ALU_SQRT) ? SQRT_TOP : i_req.b;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_x   <= n_x;
                r_y   <= n_y;
                r_cnt <= r_cnt + 6'd1;
                if (w_fin) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= (r_op == ALU_DIV) ? n_x : n_acc;
                end
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule
`default_nettype wire

// ===== sv/periodic_point_repulsion_relaxer.sv =====
// top level of the periodic point repulsion relaxer
//
//  channel   direction  transaction                  payload
//  s_axis    in         load one point / run a step  tuser op, tdata index, x, y
//  m_axis    out        one relaxed point            tdata index, x, y, max move; tlast
//  cfg       in         register write               force_gain, active_points
//
//  a load is written straight into the point memory; a timestep sums the force of every
//  other point over all periodic images, clamps each move and then commits and emits
//  the points in turn; the pace is set by the shared alu: one quotient, root or
//  multiplier bit a cycle
//  s_axis_tready is high only while the sequencer is idle
//  results leave through an output register, so a stalled m_axis holds the emit loop
//  reset is synchronous, active low; the point memories are not cleared
`default_nettype none
module periodic_point_repulsion_relaxer
    import pprr_pkg::*;
#(
    parameter int MAX_POINTS = PPRR_MAX_POINTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // point_index, coord_x, coord_y, pad
    input  wire logic        s_axis_tuser,   // operation
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // out_index, out_x, out_y, peak_move, pad
    output logic             m_axis_tlast    // last
);

`include "periodic_point_repulsion_relaxer_assert.svh"

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = (AW > 6) ? AW : 6;

    typedef enum logic [4:0] {
        S_IDLE, S_SELF_RD, S_SELF_LD, S_J_CHK, S_J_LD, S_TERM,
        S_MX2, S_MY2, S_MDIV, S_ROOT, S_UX, S_UY, S_TX, S_TY, S_NEXT_OFF,
        S_CLAMP_SH, S_SQX, S_SQY, S_LP, S_LEN, S_CXM, S_CXD, S_CYM, S_CYD,
        S_WRITE, S_EMIT_RD, S_EMIT
    } t_state;

    // configuration
    logic [23:0] r_gain;
    logic [6:0]  r_active;

    // sequencer
    t_state      r_state;
    logic        r_issued;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [2:0]  r_ox;
    logic [2:0]  r_oy;

    // per point and per term working registers
    logic [15:0] r_sx, r_sy, r_px, r_py;
    logic [17:0] r_mx, r_my;
    logic        r_negx, r_negy;
    logic [37:0] r_r2;
    logic [32:0] r_m;
    logic [26:0] r_r;
    logic [30:0] r_ux, r_uy;
    logic signed [47:0] r_ax, r_ay;
    logic [46:0] r_axm, r_aym, r_axs, r_ays;
    logic [4:0]  r_s;
    logic [62:0] r_sum;
    logic [31:0] r_lp;
    logic [47:0] r_len;
    logic [58:0] r_prod;
    logic [46:0] r_cx, r_cy;
    logic [11:0] r_best;
    logic [11:0] r_largest;

    // memories
    logic [31:0] r_pos_mem  [MAX_POINTS];
    logic [31:0] r_next_mem [MAX_POINTS];
    logic [31:0] r_pos_rd;
    logic [31:0] r_next_rd;

    // output register
    logic        r_out_valid;
    logic [5:0]  r_out_index;
    logic [15:0] r_out_x, r_out_y;
    logic [11:0] r_out_pert;
    logic        r_out_last;

    t_alu_req    w_req;
    t_alu_rsp    w_rsp;

    logic        w_in_acc;
    logic [IW-1:0] w_load_idx;
    logic        w_load_ok;
    logic [CW-1:0] w_n;
    logic        w_pos_we;
    logic [AW-1:0] w_pos_waddr;
    logic [31:0] w_pos_wdata;
    logic [AW-1:0] w_pos_raddr;
    logic        w_out_free;
    logic signed [3:0]  w_offx, w_offy;
    logic signed [19:0] w_dx, w_dy, w_ndx, w_ndy;
    logic [37:0] w_r2_sum;
    logic [47:0] w_len;
    logic [27:0] w_pert_sum;
    logic [47:0] w_cx_rnd, w_cy_rnd;
    logic [15:0] w_nx, w_ny;
    logic [11:0] w_best_n;
    logic [32:0] w_res_m;

    pprr_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_load_idx    = IW'(s_axis_tdata[5:0]);
    assign w_load_ok     = (32'(w_load_idx) < 32'(MAX_POINTS));
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // active count saturated into [2, MAX_POINTS]
    always_comb begin
        if (r_active < 7'd2) begin
            w_n = CW'(2);
        end else if (32'(r_active) > 32'(MAX_POINTS)) begin
            w_n = CW'(MAX_POINTS);
        end else begin
            w_n = CW'(r_active);
        end
    end

    // one write port: loads while idle, commits during emit
    always_comb begin
        w_pos_we    = 1'b0;
        w_pos_waddr = r_i[AW-1:0];
        w_pos_wdata = r_next_rd;
        if (r_state == S_IDLE) begin
            w_pos_we    = w_in_acc && (s_axis_tuser == OP_LOAD) && w_load_ok;
            w_pos_waddr = w_load_idx[AW-1:0];
            w_pos_wdata = {s_axis_tdata[37:22], s_axis_tdata[21:6]};
        end else if (r_state == S_EMIT) begin
            w_pos_we = w_out_free;
        end
    end
    assign w_pos_raddr = (r_state == S_J_CHK) ? r_j[AW-1:0] : r_i[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_pos_we) begin
            r_pos_mem[w_pos_waddr] <= w_pos_wdata;
        end
        r_pos_rd <= r_pos_mem[w_pos_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_next_mem[r_i[AW-1:0]] <= {w_ny, w_nx};
        end
        r_next_rd <= r_next_mem[r_i[AW-1:0]];
    end

    // separation to the current periodic image
    assign w_offx = 4'sd2 - $signed({1'b0, r_ox});
    assign w_offy = 4'sd2 - $signed({1'b0, r_oy});
    assign w_dx   = $signed({4'b0, r_sx}) - $signed({4'b0, r_px}) + $signed({w_offx, 16'b0});
    assign w_dy   = $signed({4'b0, r_sy}) - $signed({4'b0, r_py}) + $signed({w_offy, 16'b0});
    assign w_ndx  = -w_dx;
    assign w_ndy  = -w_dy;
    assign w_r2_sum = r_r2 + w_rsp.result[37:0];

    // magnitude saturates at 1.0
    assign w_res_m = ((|w_rsp.result[63:33]) || (w_rsp.result[32] && (|w_rsp.result[31:0])))
                     ? TERM_MAX : w_rsp.result[32:0];

    // clamp length and the final move
    assign w_len      = {16'b0, r_lp} << r_s;
    assign w_pert_sum = r_len[27:0] + 28'd32768;
    assign w_cx_rnd   = {1'b0, r_cx} + 48'd32768;
    assign w_cy_rnd   = {1'b0, r_cy} + 48'd32768;
    assign w_nx       = r_ax[47] ? (r_sx - w_cx_rnd[31:16]) : (r_sx + w_cx_rnd[31:16]);
    assign w_ny       = r_ay[47] ? (r_sy - w_cy_rnd[31:16]) : (r_sy + w_cy_rnd[31:16]);
    assign w_best_n   = (w_pert_sum[27:16] > r_best) ? w_pert_sum[27:16] : r_best;

    // alu request per arithmetic state
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = ALU_MUL;
        w_req.a     = 64'd0;
        w_req.b     = 64'd0;
        unique case (r_state)
            S_MX2:  begin w_req.a = {46'b0, r_mx}; w_req.b = {46'b0, r_mx}; end
            S_MY2:  begin w_req.a = {46'b0, r_my}; w_req.b = {46'b0, r_my}; end
            S_MDIV: begin
                w_req.op = ALU_DIV;
                w_req.a  = {r_gain, 40'b0};
                w_req.b  = {26'b0, r_r2};
            end
            S_ROOT: begin w_req.op = ALU_SQRT; w_req.a = {10'b0, r_r2, 16'b0}; end
            S_UX:   begin
                w_req.op = ALU_DIV;
                w_req.a  = {8'b0, r_mx, 38'b0};
                w_req.b  = {37'b0, r_r};
            end
            S_UY:   begin
                w_req.op = ALU_DIV;
                w_req.a  = {8'b0, r_my, 38'b0};
                w_req.b  = {37'b0, r_r};
            end
            S_TX:   begin w_req.a = {31'b0, r_m}; w_req.b = {33'b0, r_ux}; end
            S_TY:   begin w_req.a = {31'b0, r_m}; w_req.b = {33'b0, r_uy}; end
            S_SQX:  begin w_req.a = {17'b0, r_axs}; w_req.b = {17'b0, r_axs}; end
            S_SQY:  begin w_req.a = {17'b0, r_ays}; w_req.b = {17'b0, r_ays}; end
            S_LP:   begin w_req.op = ALU_SQRT; w_req.a = {1'b0, r_sum}; end
            S_CXM:  begin w_req.a = {17'b0, r_axs}; w_req.b = {16'b0, LIM_Q32}; end
            S_CYM:  begin w_req.a = {17'b0, r_ays}; w_req.b = {16'b0, LIM_Q32}; end
            S_CXD, S_CYD: begin
                w_req.op = ALU_DIV;
                w_req.a  = {5'b0, r_prod};
                w_req.b  = {32'b0, r_lp};
            end
            default: begin
                w_req.op = ALU_MUL;
            end
        endcase
        unique case (r_state)
            S_MX2, S_MY2, S_MDIV, S_ROOT, S_UX, S_UY, S_TX, S_TY,
            S_SQX, S_SQY, S_LP, S_CXM, S_CXD, S_CYM, S_CYD: begin
                w_req.start = !r_issued;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_gain      <= 24'd65536;
            r_active    <= 7'd64;
            r_largest   <= 12'd0;
            r_out_valid <= 1'b0;
            r_n         <= CW'(2);
            r_i         <= '0;
            r_j         <= '0;
            r_ox        <= 3'd0;
            r_oy        <= 3'd0;
            r_best      <= 12'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FORCE_GAIN:    r_gain   <= i_cfg_data;
                    CFG_ACTIVE_POINTS: r_active <= i_cfg_data[6:0];
                    default:           r_gain   <= r_gain;
                endcase
            end

            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // arithmetic states: issue once, then wait for the unit
            if (w_req.start) begin
                r_issued <= 1'b1;
            end else if (r_issued && w_rsp.done) begin
                r_issued <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (s_axis_tuser == OP_STEP)) begin
                        r_n     <= w_n;
                        r_i     <= '0;
                        r_best  <= 12'd0;
                        r_state <= S_SELF_RD;
                    end
                end
                S_SELF_RD: r_state <= S_SELF_LD;
                S_SELF_LD: begin
                    r_sx    <= r_pos_rd[15:0];
                    r_sy    <= r_pos_rd[31:16];
                    r_ax    <= '0;
                    r_ay    <= '0;
                    r_j     <= '0;
                    r_state <= S_J_CHK;
                end
                S_J_CHK: begin
                    if (r_j == r_n) begin
                        r_axm   <= acc_mag(r_ax);
                        r_aym   <= acc_mag(r_ay);
                        r_axs   <= acc_mag(r_ax);
                        r_ays   <= acc_mag(r_ay);
                        r_s     <= 5'd0;
                        r_state <= S_CLAMP_SH;
                    end else if (r_j == r_i) begin
                        r_j <= r_j + CW'(1);
                    end else begin
                        r_state <= S_J_LD;
                    end
                end
                S_J_LD: begin
                    r_px    <= r_pos_rd[15:0];
                    r_py    <= r_pos_rd[31:16];
                    r_ox    <= 3'd0;
                    r_oy    <= 3'd0;
                    r_state <= S_TERM;
                end
                S_TERM: begin
                    r_negx  <= w_dx[19];
                    r_negy  <= w_dy[19];
                    r_mx    <= w_dx[19] ? w_ndx[17:0] : w_dx[17:0];
                    r_my    <= w_dy[19] ? w_ndy[17:0] : w_dy[17:0];
                    r_state <= S_MX2;
                end
                S_MX2: if (r_issued && w_rsp.done) begin
                    r_r2    <= w_rsp.result[37:0];
                    r_state <= S_MY2;
                end
                S_MY2: if (r_issued && w_rsp.done) begin
                    r_r2    <= w_r2_sum;
                    // a coincident image contributes nothing
                    r_state <= (w_r2_sum == 38'd0) ? S_NEXT_OFF : S_MDIV;
                end
                S_MDIV: if (r_issued && w_rsp.done) begin
                    r_m     <= w_res_m;
                    r_state <= S_ROOT;
                end
                S_ROOT: if (r_issued && w_rsp.done) begin
                    r_r     <= w_rsp.result[26:0];
                    r_state <= S_UX;
                end
                S_UX: if (r_issued && w_rsp.done) begin
                    r_ux    <= w_rsp.result[30:0];
                    r_state <= S_UY;
                end
                S_UY: if (r_issued && w_rsp.done) begin
                    r_uy    <= w_rsp.result[30:0];
                    r_state <= S_TX;
                end
                S_TX: if (r_issued && w_rsp.done) begin
                    r_ax    <= acc_add(r_ax, r_negx, w_rsp.result[62:30]);
                    r_state <= S_TY;
                end
                S_TY: if (r_issued && w_rsp.done) begin
                    r_ay    <= acc_add(r_ay, r_negy, w_rsp.result[62:30]);
                    r_state <= S_NEXT_OFF;
                end
                S_NEXT_OFF: begin
                    if (r_oy == IMG_LAST) begin
                        r_oy <= 3'd0;
                        if (r_ox == IMG_LAST) begin
                            r_ox    <= 3'd0;
                            r_j     <= r_j + CW'(1);
                            r_state <= S_J_CHK;
                        end else begin
                            r_ox    <= r_ox + 3'd1;
                            r_state <= S_TERM;
                        end
                    end else begin
                        r_oy    <= r_oy + 3'd1;
                        r_state <= S_TERM;
                    end
                end
                S_CLAMP_SH: begin
                    // scale both sums below 2^31, one bit a cycle
                    if ((r_axs[46:31] == 16'd0) && (r_ays[46:31] == 16'd0)) begin
                        r_state <= S_SQX;
                    end else begin
                        r_axs <= {1'b0, r_axs[46:1]};
                        r_ays <= {1'b0, r_ays[46:1]};
                        r_s   <= r_s + 5'd1;
                    end
                end
                S_SQX: if (r_issued && w_rsp.done) begin
                    r_sum   <= w_rsp.result[62:0];
                    r_state <= S_SQY;
                end
                S_SQY: if (r_issued && w_rsp.done) begin
                    r_sum   <= r_sum + w_rsp.result[62:0];
                    r_state <= S_LP;
                end
                S_LP: if (r_issued && w_rsp.done) begin
                    r_lp    <= w_rsp.result[31:0];
                    r_state <= S_LEN;
                end
                S_LEN: begin
                    if (w_len > LIM_Q32) begin
                        r_len   <= LIM_Q32;
                        r_state <= S_CXM;
                    end else begin
                        r_len   <= w_len;
                        r_cx    <= r_axm;
                        r_cy    <= r_aym;
                        r_state <= S_WRITE;
                    end
                end
                S_CXM: if (r_issued && w_rsp.done) begin
                    r_prod  <= w_rsp.result[58:0];
                    r_state <= S_CXD;
                end
                S_CXD: if (r_issued && w_rsp.done) begin
                    r_cx    <= w_rsp.result[46:0];
                    r_state <= S_CYM;
                end
                S_CYM: if (r_issued && w_rsp.done) begin
                    r_prod  <= w_rsp.result[58:0];
                    r_state <= S_CYD;
                end
                S_CYD: if (r_issued && w_rsp.done) begin
                    r_cy    <= w_rsp.result[46:0];
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_best <= w_best_n;
                    if (r_i + CW'(1) == r_n) begin
                        r_largest <= w_best_n;
                        r_i       <= '0;
                        r_state   <= S_EMIT_RD;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_SELF_RD;
                    end
                end
                S_EMIT_RD: r_state <= S_EMIT;
                S_EMIT: begin
                    // commit and emit one point per transaction
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_index <= 6'(r_i);
                        r_out_x     <= r_next_rd[15:0];
                        r_out_y     <= r_next_rd[31:16];
                        r_out_pert  <= r_largest;
                        r_out_last  <= (r_i + CW'(1) == r_n);
                        if (r_i + CW'(1) == r_n) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_pert, r_out_y, r_out_x, r_out_index};
    assign m_axis_tlast  = r_out_last;

    `PPRR_ASSERT_NOW(a_alu_free, !w_req.start || !w_rsp.busy, "alu started while busy")
    `PPRR_ASSERT_NEXT(a_alu_runs, w_req.start, w_rsp.busy, "alu did not take request")
    `PPRR_ASSERT_NOW(a_pert_bound, !m_axis_tvalid || (m_axis_tdata[49:38] <= LIM_Q16),
                     "perturbation above clamp")
    `PPRR_ASSERT_NOW(a_index_range, (r_state == S_IDLE) || (r_i < r_n),
                     "point index beyond active count")

endmodule
`default_nettype wire
